// File: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared widths, types and the arctangent table of the compass heading block.
// ----------------------------------------------------------------------------
package chs_pkg;

   // Number of rotation cells in each vectoring chain.
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int IDX_W         = $clog2(TABLE_LEN);

   // Raw sample and scaled magnitude widths.
   localparam int IN_W  = 16;
   localparam int MAG_W = 15;

   // Square root: 24 result bits, one bit per cell.
   localparam int SQRT_W = 24;
   localparam int REM_W  = SQRT_W + 2;
   localparam int RAD_W  = 2 * SQRT_W;

   // Vector and angle widths; angles have 2^32 units per full turn.
   localparam int XY_W  = 36;
   localparam int ANG_W = 34;

   typedef logic signed [XY_W-1:0]  xy_type;
   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic [REM_W-1:0]        rem_type;
   typedef logic [SQRT_W-1:0]       root_type;
   typedef logic [RAD_W-1:0]        rad_type;
   typedef logic [MAG_W-1:0]        mag_type;

   // Side information that follows a sample down the square root chain.
   typedef struct packed {
      mag_type za;
      logic    zz;
      logic    hz;
   } z_side_type;

   // Flags that follow a sample down the polar angle chain.
   typedef struct packed {
      logic zz;
      logic hz;
   } pol_side_type;

   localparam ang_type HALF_TURN    = 34'sd2147483648;
   localparam ang_type QUARTER_TURN = 34'sd1073741824;

   // atan(2^-i), rounded, in 2^32 units per turn.
   localparam ang_type ATAN_TAB [TABLE_LEN] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

endpackage

// File: rtl/chs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// chs_sqrt_cell
// One step of a restoring integer square root: takes the top two radicand
// bits, decides one root bit and passes the rest to the next cell.
// ----------------------------------------------------------------------------
module chs_sqrt_cell (
   input  logic               clock,
   input  chs_pkg::rem_type   src_rem,
   input  chs_pkg::root_type  src_root,
   input  chs_pkg::rad_type   src_rad,
   output chs_pkg::rem_type   dst_rem,
   output chs_pkg::root_type  dst_root,
   output chs_pkg::rad_type   dst_rad
);
   import chs_pkg::*;

   rem_type  rem_sh;
   rem_type  trial;
   logic     take;
   rem_type  rem_in, rem_ff;
   root_type root_in, root_ff;
   rad_type  rad_in, rad_ff;

   // The remainder never exceeds twice the partial root, so the dropped top
   // bits are always zero.
   always_comb begin
      rem_sh  = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
      trial   = {src_root, 2'b01};
      take    = (rem_sh >= trial);
      rem_in  = take ? (rem_sh - trial) : rem_sh;
      root_in = {src_root[SQRT_W-2:0], take};
      rad_in  = {src_rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
   end

   assign dst_rem  = rem_ff;
   assign dst_root = root_ff;
   assign dst_rad  = rad_ff;

endmodule

// File: rtl/chs_cordic_cell.sv
// ----------------------------------------------------------------------------
// chs_cordic_cell
// One vectoring CORDIC rotation: drives y toward zero and accumulates the
// angle turned, with floor shifts by the cell's position in the chain.
// ----------------------------------------------------------------------------
module chs_cordic_cell (
   input  logic                      clock,
   input  logic [chs_pkg::IDX_W-1:0] stage_idx,
   input  chs_pkg::xy_type           src_x,
   input  chs_pkg::xy_type           src_y,
   input  chs_pkg::ang_type          src_ang,
   output chs_pkg::xy_type           dst_x,
   output chs_pkg::xy_type           dst_y,
   output chs_pkg::ang_type          dst_ang
);
   import chs_pkg::*;

   xy_type  dx;
   xy_type  dy;
   xy_type  x_in, x_ff;
   xy_type  y_in, y_ff;
   ang_type ang_in, ang_ff;

   always_comb begin
      dx = src_y >>> stage_idx;
      dy = src_x >>> stage_idx;
      if (!src_y[XY_W-1]) begin
         x_in   = src_x + dx;
         y_in   = src_y - dy;
         ang_in = src_ang + ATAN_TAB[stage_idx];
      end else begin
         x_in   = src_x - dx;
         y_in   = src_y + dy;
         ang_in = src_ang - ATAN_TAB[stage_idx];
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      ang_ff <= ang_in;
   end

   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_ang = ang_ff;

endmodule

// File: rtl/compass_heading_sector.sv
// ----------------------------------------------------------------------------
// compass_heading_sector
// Magnetometer sample to heading, sector, LED pattern and tilt warning.
// ----------------------------------------------------------------------------
// A sample is taken in every cycle in which start is high; busy never rises,
// so samples may follow each other back to back. Each result appears on the
// rsp_ ports for a single cycle with rsp_valid high. The delay from sample
// to result is set by the 24-cell square root chain feeding the polar angle
// CORDIC chain; the heading CORDIC runs alongside. The receiver cannot stall
// the block and must take each result in the cycle it is shown. Gains and the
// tilt limit should only be written while no sample is in flight.
// ----------------------------------------------------------------------------
module compass_heading_sector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [chs_pkg::IN_W-1:0] req_raw_x,
   input  logic signed [chs_pkg::IN_W-1:0] req_raw_y,
   input  logic signed [chs_pkg::IN_W-1:0] req_raw_z,
   output logic                            rsp_valid,
   output logic [12:0]                     rsp_heading,
   output logic [2:0]                      rsp_sector,
   output logic [7:0]                      rsp_led_pattern,
   output logic                            rsp_tilt_warning,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_addr,
   input  logic [15:0]                     csr_wdata
);
   import chs_pkg::*;

   localparam int LAT = SQRT_W + CORDIC_STAGES + 5;

   localparam logic [1:0] CSR_GAIN_X = 2'd0;
   localparam logic [1:0] CSR_GAIN_Y = 2'd1;
   localparam logic [1:0] CSR_GAIN_Z = 2'd2;
   localparam logic [1:0] CSR_TILT   = 2'd3;

   localparam logic [15:0] GAIN_X_RST = 16'd57471;
   localparam logic [15:0] GAIN_Y_RST = 16'd60960;
   localparam logic [15:0] GAIN_Z_RST = 16'd57759;
   localparam logic [6:0]  TILT_RST   = 7'd70;

   localparam int HEADING_SCALE = 5760;
   localparam int SECTOR_SPAN   = 720;
   localparam int SECTOR_HALF   = 360;
   localparam int DEG_PER_TURN  = 360;

   function automatic logic [IN_W-1:0] abs16(input logic signed [IN_W-1:0] v);
      logic [IN_W-1:0] r;
      r = v[IN_W-1] ? (~v + 16'd1) : v;
      return r;
   endfunction

   // Configuration registers.
   logic [15:0] gain_x_ff, gain_y_ff, gain_z_ff;
   logic [6:0]  tilt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff <= GAIN_X_RST;
         gain_y_ff <= GAIN_Y_RST;
         gain_z_ff <= GAIN_Z_RST;
         tilt_ff   <= TILT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GAIN_X: gain_x_ff <= csr_wdata;
            CSR_GAIN_Y: gain_y_ff <= csr_wdata;
            CSR_GAIN_Z: gain_z_ff <= csr_wdata;
            CSR_TILT:   tilt_ff   <= csr_wdata[6:0];
            default:    tilt_ff   <= tilt_ff;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Valid bits that travel alongside the data path.
   logic vline_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vline_ff[i] <= 1'b0;
         end
      end else begin
         vline_ff[0] <= accept;
         for (int i = 1; i < LAT; i++) begin
            vline_ff[i] <= vline_ff[i-1];
         end
      end
   end

   // Stage 1: scale each axis magnitude, truncating toward zero.
   logic [IN_W-1:0] abs_x, abs_y, abs_z;
   logic [31:0]     prod_x, prod_y, prod_z;
   mag_type         mx1_ff, my1_ff, mz1_ff;
   logic            sgnx1_ff, sgny1_ff;

   always_comb begin
      abs_x  = abs16(req_raw_x);
      abs_y  = abs16(req_raw_y);
      abs_z  = abs16(req_raw_z);
      prod_x = {16'b0, abs_x} * {16'b0, gain_x_ff};
      prod_y = {16'b0, abs_y} * {16'b0, gain_y_ff};
      prod_z = {16'b0, abs_z} * {16'b0, gain_z_ff};
   end

   always_ff @(posedge clock) begin
      mx1_ff   <= prod_x[30:16];
      my1_ff   <= prod_y[30:16];
      mz1_ff   <= prod_z[30:16];
      sgnx1_ff <= req_raw_x[IN_W-1];
      sgny1_ff <= req_raw_y[IN_W-1];
   end

   // Stage 2: squares of the horizontal components and zero tests.
   mag_type                mx2_ff, my2_ff, mz2_ff;
   logic [2*MAG_W-1:0]     sqx2_ff, sqy2_ff;
   logic                   xneg2_ff, sgny2_ff, hz2_ff, zz2_ff;

   always_ff @(posedge clock) begin
      mx2_ff   <= mx1_ff;
      my2_ff   <= my1_ff;
      mz2_ff   <= mz1_ff;
      sqx2_ff  <= (2*MAG_W)'(mx1_ff) * (2*MAG_W)'(mx1_ff);
      sqy2_ff  <= (2*MAG_W)'(my1_ff) * (2*MAG_W)'(my1_ff);
      xneg2_ff <= sgnx1_ff && (mx1_ff != '0);
      sgny2_ff <= sgny1_ff;
      hz2_ff   <= (mx1_ff == '0) && (my1_ff == '0);
      zz2_ff   <= (mz1_ff == '0);
   end

   // Stage 3: radicand and the azimuth vector folded into the right half.
   logic [2*MAG_W:0] sum3_ff;
   xy_type           azy_mag;
   xy_type           azx3_ff, azy3_ff;
   ang_type          aza3_ff;
   z_side_type       zline_ff [SQRT_W+1];

   assign azy_mag = {5'b0, my2_ff, 16'b0};

   always_ff @(posedge clock) begin
      sum3_ff     <= {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      azx3_ff     <= {5'b0, mx2_ff, 16'b0};
      azy3_ff     <= (xneg2_ff ^ sgny2_ff) ? -azy_mag : azy_mag;
      aza3_ff     <= xneg2_ff ? HALF_TURN : '0;
      zline_ff[0] <= '{za: mz2_ff, zz: zz2_ff, hz: hz2_ff};
      for (int i = 1; i <= SQRT_W; i++) begin
         zline_ff[i] <= zline_ff[i-1];
      end
   end

   // Square root chain: h = floor(sqrt(sum * 2^16)).
   rem_type  sq_rem  [SQRT_W+1];
   root_type sq_root [SQRT_W+1];
   rad_type  sq_rad  [SQRT_W+1];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = {1'b0, sum3_ff, 16'b0};

   for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
      chs_sqrt_cell u_cell (
         .clock    (clock),
         .src_rem  (sq_rem[k]),
         .src_root (sq_root[k]),
         .src_rad  (sq_rad[k]),
         .dst_rem  (sq_rem[k+1]),
         .dst_root (sq_root[k+1]),
         .dst_rad  (sq_rad[k+1])
      );
   end

   // Azimuth chain.
   xy_type  az_x   [CORDIC_STAGES+1];
   xy_type  az_y   [CORDIC_STAGES+1];
   ang_type az_ang [CORDIC_STAGES+1];

   assign az_x[0]   = azx3_ff;
   assign az_y[0]   = azy3_ff;
   assign az_ang[0] = aza3_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_az
      chs_cordic_cell u_cell (
         .clock     (clock),
         .stage_idx (IDX_W'(k)),
         .src_x     (az_x[k]),
         .src_y     (az_y[k]),
         .src_ang   (az_ang[k]),
         .dst_x     (az_x[k+1]),
         .dst_y     (az_y[k+1]),
         .dst_ang   (az_ang[k+1])
      );
   end

   // Polar angle chain on (h * 2^8, |z| * 2^16).
   xy_type       pc_x   [CORDIC_STAGES+1];
   xy_type       pc_y   [CORDIC_STAGES+1];
   ang_type      pc_ang [CORDIC_STAGES+1];
   pol_side_type pline_ff [CORDIC_STAGES];

   assign pc_x[0]   = {4'b0, sq_root[SQRT_W], 8'b0};
   assign pc_y[0]   = {5'b0, zline_ff[SQRT_W].za, 16'b0};
   assign pc_ang[0] = '0;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_pc
      chs_cordic_cell u_cell (
         .clock     (clock),
         .stage_idx (IDX_W'(k)),
         .src_x     (pc_x[k]),
         .src_y     (pc_y[k]),
         .src_ang   (pc_ang[k]),
         .dst_x     (pc_x[k+1]),
         .dst_y     (pc_y[k+1]),
         .dst_ang   (pc_ang[k+1])
      );
   end

   always_ff @(posedge clock) begin
      pline_ff[0] <= '{zz: zline_ff[SQRT_W].zz, hz: zline_ff[SQRT_W].hz};
      for (int i = 1; i < CORDIC_STAGES; i++) begin
         pline_ff[i] <= pline_ff[i-1];
      end
   end

   // Heading from the azimuth, delayed to meet the polar angle.
   logic [44:0] head_prod;
   logic [12:0] head_c;
   logic [12:0] hline_ff [SQRT_W];

   always_comb begin
      head_prod = {13'b0, az_ang[CORDIC_STAGES][31:0]} * 45'(HEADING_SCALE);
      head_c    = head_prod[44:32];
   end

   always_ff @(posedge clock) begin
      hline_ff[0] <= head_c;
      for (int i = 1; i < SQRT_W; i++) begin
         hline_ff[i] <= hline_ff[i-1];
      end
   end

   // Final stage one: special cases, sector and clamped polar angle.
   pol_side_type fl;
   logic [12:0]  head_sel;
   logic [3:0]   sec_cnt;
   logic [31:0]  polar_sel;
   logic [12:0]  head_f1_ff;
   logic [2:0]   sec_f1_ff;
   logic [31:0]  polar_f1_ff;

   always_comb begin
      fl       = pline_ff[CORDIC_STAGES-1];
      head_sel = fl.hz ? '0 : hline_ff[SQRT_W-1];
      // Counting all eight boundaries wraps the top slice back to sector 0.
      sec_cnt = '0;
      for (int k = 1; k <= 8; k++) begin
         sec_cnt = sec_cnt + 4'(head_sel >= 13'(SECTOR_SPAN * k - SECTOR_HALF));
      end
      priority if (fl.zz) begin
         polar_sel = '0;
      end else if (fl.hz) begin
         polar_sel = QUARTER_TURN[31:0];
      end else if (pc_ang[CORDIC_STAGES][ANG_W-1]) begin
         polar_sel = '0;
      end else begin
         polar_sel = pc_ang[CORDIC_STAGES][31:0];
      end
   end

   always_ff @(posedge clock) begin
      head_f1_ff  <= head_sel;
      sec_f1_ff   <= sec_cnt[2:0];
      polar_f1_ff <= polar_sel;
   end

   // Final stage two: tilt compare and LED decode into the output registers.
   logic [40:0] polar_deg;
   logic [40:0] limit_scaled;
   logic [12:0] heading_ff;
   logic [2:0]  sector_ff;
   logic [7:0]  led_ff;
   logic        tilt_ff_out;

   always_comb begin
      polar_deg    = {9'b0, polar_f1_ff} * 41'(DEG_PER_TURN);
      limit_scaled = {2'b0, tilt_ff, 32'b0};
   end

   always_ff @(posedge clock) begin
      heading_ff  <= head_f1_ff;
      sector_ff   <= sec_f1_ff;
      led_ff      <= 8'b1 << (sec_f1_ff + 3'd4);
      tilt_ff_out <= (polar_deg >= limit_scaled);
   end

   assign rsp_valid        = vline_ff[LAT-1];
   assign rsp_heading      = heading_ff;
   assign rsp_sector       = sector_ff;
   assign rsp_led_pattern  = led_ff;
   assign rsp_tilt_warning = tilt_ff_out;

endmodule
